// File: design/mlbd_pkg.sv
package mlbd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int W_SIZE_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_SIZE_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    localparam int CH_W       = 8;
    localparam int SUM_W      = CH_W + 1;
    localparam int NUM_CH     = 4;
    localparam int PAIR_W     = NUM_CH * SUM_W;
    localparam int POS_W      = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PAIR_W-1:0] pair_t;

    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
        pair_t              data;
    } line_wr_t;

    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
    } line_rd_t;

    typedef struct packed {
        logic             h_one;
        pair_t            pair;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             done;
    } tap_t;

    function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
        int unsigned r;
        r = 32'(v);
        if (r == 0)
            r = 1;
        else if (r > maxv)
            r = maxv;
        return r;
    endfunction

    function automatic pair_t pair_add(pair_t a, pair_t b);
        pair_t r;
        for (int c = 0; c < NUM_CH; c++)
            r[c*SUM_W +: SUM_W] = a[c*SUM_W +: SUM_W] + b[c*SUM_W +: SUM_W];
        return r;
    endfunction

endpackage

// File: design/mlbd_ifs.sv
interface mlbd_pix_if;
    logic                      valid;
    logic                      ready;
    logic [mlbd_pkg::CH_W-1:0] red_in;
    logic [mlbd_pkg::CH_W-1:0] green_in;
    logic [mlbd_pkg::CH_W-1:0] blue_in;
    logic [mlbd_pkg::CH_W-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface mlbd_res_if;
    logic                       valid;
    logic                       ready;
    logic [mlbd_pkg::CH_W-1:0]  red_out;
    logic [mlbd_pkg::CH_W-1:0]  green_out;
    logic [mlbd_pkg::CH_W-1:0]  blue_out;
    logic [mlbd_pkg::CH_W-1:0]  alpha_out;
    logic [mlbd_pkg::POS_W-1:0] out_col;
    logic [mlbd_pkg::POS_W-1:0] out_row;
    logic                       level_done;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, out_col,
                     out_row, level_done, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, out_col,
                     out_row, level_done, output ready);
endinterface

// File: design/mip_level_box_downsample.sv
// 2x2 box-filter mip reduction for RGBA8. Source pixels enter in raster order, one item per
// cycle unless the output stalls; results pass a tap register, then the output register, and
// one output item per cycle can leave. Horizontal pair sums of even rows sit in a 2048-entry
// line store (one write port, one registered read port); odd rows read them back to finish
// each block. Program src_width and src_height only while idle: a write restarts the level.
module mip_level_box_downsample (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [mlbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    mlbd_pix_if.sink                          pix,
    mlbd_res_if.source                        res
);

    mlbd_pkg::line_wr_t wr;
    mlbd_pkg::line_rd_t rd;
    mlbd_pkg::pair_t    above;
    mlbd_pkg::pair_t    px;
    mlbd_pkg::tap_t     tap;
    logic               tap_emit;
    logic               acc;

    logic               s1_valid_reg, s1_valid_next;
    mlbd_pkg::tap_t     s1_tap_reg;
    logic               out_valid_reg, out_valid_next;
    logic               s1_move;

    logic [mlbd_pkg::NUM_CH*mlbd_pkg::CH_W-1:0] avg;
    logic [mlbd_pkg::NUM_CH*mlbd_pkg::CH_W-1:0] avg_reg;
    logic [mlbd_pkg::POS_W-1:0]                 col_reg;
    logic [mlbd_pkg::POS_W-1:0]                 row_reg;
    logic                                       done_reg;
    logic [mlbd_pkg::SUM_W:0]                   sum;

    assign px = {1'b0, pix.alpha_in, 1'b0, pix.blue_in, 1'b0, pix.green_in, 1'b0, pix.red_in};

    assign s1_move   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign pix.ready = !s1_valid_reg || !out_valid_reg || res.ready;
    assign acc       = pix.valid && pix.ready;

    mlbd_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (mlbd_pkg::cfg_reg_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .acc       (acc),
        .px        (px),
        .wr        (wr),
        .rd        (rd),
        .tap       (tap),
        .tap_emit  (tap_emit)
    );

    mlbd_line_store u_line_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (above)
    );

    always_comb
    begin
        sum = '0;
        for (int c = 0; c < mlbd_pkg::NUM_CH; c++)
        begin
            if (s1_tap_reg.h_one)
                sum = {s1_tap_reg.pair[c*mlbd_pkg::SUM_W +: mlbd_pkg::SUM_W], 1'b0};
            else
                sum = {1'b0, above[c*mlbd_pkg::SUM_W +: mlbd_pkg::SUM_W]}
                    + {1'b0, s1_tap_reg.pair[c*mlbd_pkg::SUM_W +: mlbd_pkg::SUM_W]};
            avg[c*mlbd_pkg::CH_W +: mlbd_pkg::CH_W] = sum[mlbd_pkg::SUM_W:2];
        end

        s1_valid_next = s1_valid_reg;
        if (acc)
            s1_valid_next = tap_emit;
        else if (s1_move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_tap_reg <= tap;
        end
        if (s1_move)
        begin
            avg_reg  <= avg;
            col_reg  <= s1_tap_reg.col;
            row_reg  <= s1_tap_reg.row;
            done_reg <= s1_tap_reg.done;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.red_out    = avg_reg[0*mlbd_pkg::CH_W +: mlbd_pkg::CH_W];
    assign res.green_out  = avg_reg[1*mlbd_pkg::CH_W +: mlbd_pkg::CH_W];
    assign res.blue_out   = avg_reg[2*mlbd_pkg::CH_W +: mlbd_pkg::CH_W];
    assign res.alpha_out  = avg_reg[3*mlbd_pkg::CH_W +: mlbd_pkg::CH_W];
    assign res.out_col    = col_reg;
    assign res.out_row    = row_reg;
    assign res.level_done = done_reg;

endmodule

// File: design/mlbd_line_store.sv
module mlbd_line_store (
    input  logic               clk,
    input  mlbd_pkg::line_wr_t wr,
    input  mlbd_pkg::line_rd_t rd,
    output mlbd_pkg::pair_t    rd_data
);

    mlbd_pkg::pair_t line_mem [mlbd_pkg::LINE_DEPTH];
    mlbd_pkg::pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            line_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= line_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/mlbd_walk.sv
module mlbd_walk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  mlbd_pkg::cfg_reg_t                  cfg_index,
    input  logic [mlbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                acc,
    input  mlbd_pkg::pair_t                     px,
    output mlbd_pkg::line_wr_t                  wr,
    output mlbd_pkg::line_rd_t                  rd,
    output mlbd_pkg::tap_t                      tap,
    output logic                                tap_emit
);

    logic [mlbd_pkg::W_SIZE_W-1:0] width_reg,  width_next;
    logic [mlbd_pkg::H_SIZE_W-1:0] height_reg, height_next;
    logic [mlbd_pkg::COL_W-1:0]    col_reg,    col_next;
    logic [mlbd_pkg::ROW_W-1:0]    row_reg,    row_next;
    mlbd_pkg::pair_t               pair_sum_reg, pair_sum_next;

    logic [mlbd_pkg::COL_W-1:0]    ow;
    logic [mlbd_pkg::ROW_W-1:0]    oh;
    logic [mlbd_pkg::W_SIZE_W-1:0] col_inc;
    logic [mlbd_pkg::H_SIZE_W-1:0] row_inc;
    logic [mlbd_pkg::LINE_AW-1:0]  idx;
    logic [mlbd_pkg::ROW_W-1:0]    orow;
    logic                          w_one;
    logic                          h_one;
    logic                          have_pair;
    logic                          row_in;
    logic                          store_ok;
    mlbd_pkg::pair_t               pair_val;

    always_comb
    begin
        w_one = (width_reg == mlbd_pkg::W_SIZE_W'(1));
        h_one = (height_reg == mlbd_pkg::H_SIZE_W'(1));
        ow = mlbd_pkg::COL_W'(width_reg >> 1);
        if (ow == '0)
            ow = mlbd_pkg::COL_W'(1);
        oh = mlbd_pkg::ROW_W'(height_reg >> 1);
        if (oh == '0)
            oh = mlbd_pkg::ROW_W'(1);

        pair_val  = w_one ? mlbd_pkg::pair_add(px, px) : mlbd_pkg::pair_add(pair_sum_reg, px);
        have_pair = w_one || (col_reg[0] && ({1'b0, col_reg} < {ow, 1'b0}));
        row_in    = {1'b0, row_reg} < {oh, 1'b0};
        store_ok  = !h_one && row_in;
        idx       = col_reg[mlbd_pkg::COL_W-1:1];
        orow      = row_reg >> 1;

        wr.en   = acc && have_pair && store_ok && !row_reg[0];
        wr.addr = idx;
        wr.data = pair_val;
        rd.en   = acc && have_pair && store_ok && row_reg[0];
        rd.addr = idx;

        tap_emit  = acc && have_pair && (h_one || (store_ok && row_reg[0]));
        tap.h_one = h_one;
        tap.pair  = pair_val;
        tap.col   = mlbd_pkg::POS_W'(idx);
        tap.row   = mlbd_pkg::POS_W'(orow);
        tap.done  = ({1'b0, idx} == ow - 1'b1) && (orow == oh - 1'b1);

        col_inc = mlbd_pkg::W_SIZE_W'(col_reg) + 1'b1;
        row_inc = mlbd_pkg::H_SIZE_W'(row_reg) + 1'b1;

        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pair_sum_next = pair_sum_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mlbd_pkg::REG_SRC_WIDTH:
                    width_next = mlbd_pkg::W_SIZE_W'(
                        mlbd_pkg::clamp_size(cfg_data, mlbd_pkg::MAX_WIDTH));
                mlbd_pkg::REG_SRC_HEIGHT:
                    height_next = mlbd_pkg::H_SIZE_W'(
                        mlbd_pkg::clamp_size(cfg_data, mlbd_pkg::MAX_HEIGHT));
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (acc)
        begin
            if (!w_one && !col_reg[0])
                pair_sum_next = px;
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = (row_inc >= height_reg) ? '0 : mlbd_pkg::ROW_W'(row_inc);
            end
            else
            begin
                col_next = mlbd_pkg::COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mlbd_pkg::W_SIZE_W'(1);
            height_reg <= mlbd_pkg::H_SIZE_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_sum_reg <= pair_sum_next;
    end

endmodule

// File: design/mlbd_checker.sv
module mlbd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [mlbd_pkg::CH_W-1:0]  red_out,
    input  logic [mlbd_pkg::CH_W-1:0]  green_out,
    input  logic [mlbd_pkg::CH_W-1:0]  blue_out,
    input  logic [mlbd_pkg::CH_W-1:0]  alpha_out,
    input  logic [mlbd_pkg::POS_W-1:0] out_col,
    input  logic [mlbd_pkg::POS_W-1:0] out_row,
    input  logic                       level_done
);

    logic in_acc;
    logic out_acc;
    logic after_done_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            after_done_reg <= 1'b0;
        else if (out_acc)
            after_done_reg <= level_done;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(alpha_out) && $stable(out_col)
            && $stable(out_row) && $stable(level_done))
        else $error("stalled output item changed");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_acc && !$past(in_acc) |=> !out_valid)
        else $error("output item with no source item");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_level_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && after_done_reg |-> out_col == '0 && out_row == '0)
        else $error("new level does not start at origin");

endmodule

bind mip_level_box_downsample mlbd_checker u_mlbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pix.valid),
    .in_ready   (pix.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .red_out    (res.red_out),
    .green_out  (res.green_out),
    .blue_out   (res.blue_out),
    .alpha_out  (res.alpha_out),
    .out_col    (res.out_col),
    .out_row    (res.out_row),
    .level_done (res.level_done)
);

// File: tb/sv/tb_mip_level_box_downsample.sv
`timescale 1ns / 1ps

module tb_mip_level_box_downsample;

    typedef struct packed {
        logic [mlbd_pkg::CH_W-1:0] red;
        logic [mlbd_pkg::CH_W-1:0] green;
        logic [mlbd_pkg::CH_W-1:0] blue;
        logic [mlbd_pkg::CH_W-1:0] alpha;
    } pix_t;

    typedef struct packed {
        logic [mlbd_pkg::CH_W-1:0]  red;
        logic [mlbd_pkg::CH_W-1:0]  green;
        logic [mlbd_pkg::CH_W-1:0]  blue;
        logic [mlbd_pkg::CH_W-1:0]  alpha;
        logic [mlbd_pkg::POS_W-1:0] col;
        logic [mlbd_pkg::POS_W-1:0] row;
        logic                       done;
    } mip_px_t;

    typedef logic [mlbd_pkg::NUM_CH-1:0][mlbd_pkg::SUM_W-1:0] quad_t;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 580;
    localparam int LARGE_PIXELS  = 40;
    localparam int CHAIN_DIM     = 32;
    localparam int MAX_REPORTS   = 10;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    mlbd_pkg::cfg_reg_t              cfg_index;
    logic [mlbd_pkg::CFG_DATA_W-1:0] cfg_data;

    mlbd_pix_if pix ();
    mlbd_res_if res ();

    mip_level_box_downsample dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix.sink),
        .res       (res.source)
    );

    int unsigned lvl_w;
    int unsigned lvl_h;
    int unsigned col_pos;
    int unsigned row_pos;
    quad_t       pair_acc;
    quad_t       line_mem [mlbd_pkg::LINE_DEPTH];
    mip_px_t     expected_px [$];
    pix_t        chain_out [CHAIN_DIM][CHAIN_DIM];
    pix_t        chain_img [CHAIN_DIM][CHAIN_DIM];

    int err_count  = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int ready_mode = 0;
    int ready_left = 0;
    int ready_tick = 0;

    always #4 clk = ~clk;

    function automatic int unsigned fit_size(int unsigned v, int unsigned top);
        int unsigned r;
        r = 32'(mlbd_pkg::CFG_DATA_W'(v));
        if (r == 0)
            r = 1;
        else if (r > top)
            r = top;
        return r;
    endfunction

    function automatic quad_t widen(pix_t p);
        quad_t q;
        q[0] = mlbd_pkg::SUM_W'(p.red);
        q[1] = mlbd_pkg::SUM_W'(p.green);
        q[2] = mlbd_pkg::SUM_W'(p.blue);
        q[3] = mlbd_pkg::SUM_W'(p.alpha);
        return q;
    endfunction

    function automatic pix_t rand_pixel();
        pix_t                      p;
        logic [mlbd_pkg::CH_W-1:0] ch [mlbd_pkg::NUM_CH];
        for (int c = 0; c < mlbd_pkg::NUM_CH; c++)
        begin
            case ($urandom_range(0, 7))
                0:       ch[c] = '0;
                1:       ch[c] = '1;
                default: ch[c] = mlbd_pkg::CH_W'($urandom_range(0, 255));
            endcase
        end
        p.red   = ch[0];
        p.green = ch[1];
        p.blue  = ch[2];
        p.alpha = ch[3];
        return p;
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return $urandom_range(13, 40);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic void downsample_pixel(pix_t p);
        quad_t       px;
        quad_t       pr;
        int unsigned ow;
        int unsigned oh;
        int unsigned idx;
        int unsigned s [mlbd_pkg::NUM_CH];
        logic        have_pair;
        logic        emit;
        mip_px_t     o;
        ow        = (lvl_w / 2 != 0) ? lvl_w / 2 : 1;
        oh        = (lvl_h / 2 != 0) ? lvl_h / 2 : 1;
        px        = widen(p);
        pr        = '0;
        idx       = col_pos / 2;
        have_pair = 1'b0;
        emit      = 1'b0;
        if (lvl_w == 1)
        begin
            for (int c = 0; c < mlbd_pkg::NUM_CH; c++)
                pr[c] = px[c] << 1;
            have_pair = 1'b1;
        end
        else if (col_pos % 2 == 0)
            pair_acc = px;
        else if (col_pos < 2 * ow)
        begin
            for (int c = 0; c < mlbd_pkg::NUM_CH; c++)
                pr[c] = pair_acc[c] + px[c];
            have_pair = 1'b1;
        end
        if (have_pair)
        begin
            if (lvl_h == 1)
            begin
                for (int c = 0; c < mlbd_pkg::NUM_CH; c++)
                    s[c] = 2 * pr[c];
                emit = 1'b1;
            end
            else if (row_pos < 2 * oh)
            begin
                if (row_pos % 2 == 0)
                    line_mem[idx] = pr;
                else
                begin
                    for (int c = 0; c < mlbd_pkg::NUM_CH; c++)
                        s[c] = line_mem[idx][c] + pr[c];
                    emit = 1'b1;
                end
            end
        end
        if (emit)
        begin
            o.red   = mlbd_pkg::CH_W'(s[0] / 4);
            o.green = mlbd_pkg::CH_W'(s[1] / 4);
            o.blue  = mlbd_pkg::CH_W'(s[2] / 4);
            o.alpha = mlbd_pkg::CH_W'(s[3] / 4);
            o.col   = mlbd_pkg::POS_W'(idx);
            o.row   = mlbd_pkg::POS_W'(row_pos / 2);
            o.done  = (idx == ow - 1) && (row_pos / 2 == oh - 1);
            expected_px = {expected_px, o};
            if (idx < CHAIN_DIM && row_pos / 2 < CHAIN_DIM)
                chain_out[row_pos / 2][idx] = {o.red, o.green, o.blue, o.alpha};
        end
        col_pos++;
        if (col_pos >= lvl_w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= lvl_h)
                row_pos = 0;
        end
    endfunction

    task automatic send_pixel(input pix_t p);
        if (gap_left > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        pix.valid    <= 1'b1;
        pix.red_in   <= p.red;
        pix.green_in <= p.green;
        pix.blue_in  <= p.blue;
        pix.alpha_in <= p.alpha;
        do
            @(posedge clk);
        while (!pix.ready);
        downsample_pixel(p);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20)
                                                     : $urandom_range(1, 4);
        end
    endtask

    task automatic send_frame(input int unsigned count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    task automatic drain_results();
        pix.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_px.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= mlbd_pkg::REG_SRC_WIDTH;
        cfg_data  <= mlbd_pkg::CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= mlbd_pkg::REG_SRC_HEIGHT;
        cfg_data  <= mlbd_pkg::CFG_DATA_W'(h);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lvl_w   = fit_size(w, mlbd_pkg::MAX_WIDTH);
        lvl_h   = fit_size(h, mlbd_pkg::MAX_HEIGHT);
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic test_unit_size();
        set_size(0, 0);
        send_pixel('1);
        send_pixel('0);
        send_pixel(rand_pixel());
    endtask

    task automatic test_box_floor();
        set_size(2, 2);
        send_pixel('1);
        send_pixel('1);
        send_pixel('1);
        send_pixel('{8'd254, 8'd253, 8'd252, 8'd255});
    endtask

    task automatic test_odd_edges();
        set_size(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2 != 0) ? pix_t'('1) : pix_t'('0));
    endtask

    task automatic test_single_row();
        set_size(4, 1);
        send_frame(4);
    endtask

    task automatic test_single_col();
        set_size(1, 4);
        send_frame(4);
    endtask

    task automatic test_mip_chain();
        int unsigned w;
        int unsigned h;
        w = 21;
        h = 14;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                chain_img[r][c] = rand_pixel();
        forever
        begin
            set_size(w, h);
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++)
                    send_pixel(chain_img[r][c]);
            drain_results();
            if (w == 1 && h == 1)
                break;
            w = (w / 2 != 0) ? w / 2 : 1;
            h = (h / 2 != 0) ? h / 2 : 1;
            chain_img = chain_out;
        end
    endtask

    task automatic test_largest();
        set_size(32'h1FFF, 1);
        send_frame(LARGE_PIXELS);
        set_size(2, mlbd_pkg::MAX_HEIGHT + 1);
        send_frame(LARGE_PIXELS);
        set_size(1, 32'h1FFF);
        send_frame(LARGE_PIXELS);
    endtask

    task automatic test_random_levels();
        int unsigned sent;
        int unsigned n;
        int unsigned area;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            set_size(pick_dim(), pick_dim());
            area = lvl_w * lvl_h;
            case ($urandom_range(0, 7))
                0:       n = $urandom_range(1, area);
                1:       n = 2 * area + $urandom_range(0, area - 1);
                default: n = area * $urandom_range(1, 2);
            endcase
            if (n > RANDOM_PIXELS - sent)
                n = RANDOM_PIXELS - sent;
            for (int i = 0; i < n; i++)
            begin
                send_pixel(rand_pixel());
                // hold off until the block has emptied, mid-level
                if ($urandom_range(0, 199) == 0)
                    drain_results();
            end
            sent += n;
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 200);
        end
        else
            ready_left--;
        ready_tick++;
        case (ready_mode)
            0:       res.ready <= 1'b1;
            1:       res.ready <= 1'($urandom_range(0, 1));
            2:       res.ready <= ($urandom_range(0, 3) == 0);
            default: res.ready <= (ready_tick % 7 < 4);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        mip_px_t got;
        mip_px_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.red_out, res.green_out, res.blue_out, res.alpha_out,
                    res.out_col, res.out_row, res.level_done};
            if (expected_px.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected item: rgba %h %h %h %h col %0d row %0d done %b",
                             got.red, got.green, got.blue, got.alpha,
                             got.col, got.row, got.done);
            end
            else
            begin
                want = expected_px.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected rgba %h %h %h %h col %0d row %0d done %b,",
                                 want.red, want.green, want.blue, want.alpha,
                                 want.col, want.row, want.done);
                        $display("          got rgba %h %h %h %h col %0d row %0d done %b",
                                 got.red, got.green, got.blue, got.alpha,
                                 got.col, got.row, got.done);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = mlbd_pkg::REG_SRC_WIDTH;
        cfg_data     = '0;
        pix.valid    = 1'b0;
        pix.red_in   = '0;
        pix.green_in = '0;
        pix.blue_in  = '0;
        pix.alpha_in = '0;
        lvl_w        = 1;
        lvl_h        = 1;
        col_pos      = 0;
        row_pos      = 0;
        pair_acc     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unit_size();
        test_box_floor();
        test_odd_edges();
        test_single_row();
        test_single_col();
        test_mip_chain();
        test_largest();
        test_random_levels();
        drain_results();
        if (err_count == 0 && expected_px.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: mip_level_box_downsample.f
design/mlbd_pkg.sv
design/mlbd_ifs.sv
design/mlbd_line_store.sv
design/mlbd_walk.sv
design/mip_level_box_downsample.sv
design/mlbd_checker.sv
tb/sv/tb_mip_level_box_downsample.sv
